/* design/hpec_pkg.sv */
// ----------------------------------------------------------------------------
// hpec_pkg
// Shared types and constants of the hot pixel event counter.
// ----------------------------------------------------------------------------
`default_nettype none

package hpec_pkg;

    // Item kinds on the request channel
    typedef enum logic [1:0] {
        KIND_EVENT = 2'd0,
        KIND_EOM   = 2'd1,
        KIND_QUERY = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_IMAGE_HEIGHT       = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH        = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD_FRACTION = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [10:0] HEIGHT_RESET   = 11'd260;
    localparam logic [10:0] WIDTH_RESET    = 11'd346;
    localparam logic [16:0] FRACTION_RESET = 17'd49152;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    // Linear pixel index: up to 1023 * 2047 + 1023
    localparam int LIN_W = 21;

    localparam int COUNT_W = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Threshold product: 17-bit fraction times 32-bit message number, >> 16
    localparam int PROD_W = 49;
    localparam int THR_W  = 33;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
    } hpec_in_t;

    typedef struct packed {
        logic [31:0] fire_count;
        logic        is_bad;
        logic        status;
    } hpec_out_t;

    typedef struct packed {
        logic [10:0] image_height;
        logic [10:0] image_width;
        logic [16:0] threshold_fraction;
    } hpec_cfg_t;

    // One pixel store entry
    typedef struct packed {
        logic [31:0] stamp;
        logic [31:0] count;
    } hpec_entry_t;

    localparam int ENTRY_W = $bits(hpec_entry_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_MODIFY,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

/* design/hpec_ram.sv */
// ----------------------------------------------------------------------------
// hpec_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hpec_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/hpec_cfg.sv */
// ----------------------------------------------------------------------------
// hpec_cfg
// Configuration register file: sensor size and bad-pixel fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module hpec_cfg
    import hpec_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output hpec_cfg_t                   cfg
);

    hpec_cfg_t cfg_reg;
    hpec_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_IMAGE_HEIGHT:       cfg_next.image_height       = cfg_data[10:0];
                CFG_IMAGE_WIDTH:        cfg_next.image_width        = cfg_data[10:0];
                CFG_THRESHOLD_FRACTION: cfg_next.threshold_fraction = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_height       <= HEIGHT_RESET;
            cfg_reg.image_width        <= WIDTH_RESET;
            cfg_reg.threshold_fraction <= FRACTION_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* design/hpec_locate.sv */
// ----------------------------------------------------------------------------
// hpec_locate
// Registered linear pixel index (x * height + y) and sensor bounds check.
// ----------------------------------------------------------------------------
`default_nettype none

module hpec_locate
    import hpec_pkg::*;
#(
    parameter int MAX_PIXELS = 131072
) (
    input  wire logic      aclk,
    input  wire logic [9:0] pixel_x,
    input  wire logic [9:0] pixel_y,
    input  wire hpec_cfg_t cfg,
    output logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] index,
    output logic           in_sensor
);

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    logic [LIN_W-1:0] lin;
    logic             in_sensor_c;

    assign lin = LIN_W'(pixel_x) * LIN_W'(cfg.image_height) + LIN_W'(pixel_y);

    assign in_sensor_c = ({1'b0, pixel_x} < cfg.image_width)
                      && ({1'b0, pixel_y} < cfg.image_height)
                      && (lin < LIN_W'(MAX_PIXELS));

    always_ff @(posedge aclk) begin
        index     <= lin[ADDR_W-1:0];
        in_sensor <= in_sensor_c;
    end

endmodule

`default_nettype wire

/* design/hot_pixel_event_counter_top.sv */
// ----------------------------------------------------------------------------
// hot_pixel_event_counter_top
// Per-pixel count of messages in which the pixel fired, with a hot pixel flag.
// ----------------------------------------------------------------------------
// Sequence: an event request is accepted, indexed, read and written back; it
//   is dropped after indexing when outside the sensor. An end-of-message
//   request only advances the message counter. A query is accepted, indexed,
//   read when inside the sensor, then held in ST_RESP while a result stalls.
// Flow: one request at a time; events read-modify-write the single store port pair.
// Reset: aresetn (sync, active low) clears control state, then a clearing pass
//   writes all MAX_PIXELS store entries, one per cycle, before s_ready rises.
// ----------------------------------------------------------------------------
`default_nettype none

module hot_pixel_event_counter_top
    import hpec_pkg::*;
#(
    parameter int MAX_PIXELS = 131072
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // request channel
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire hpec_in_t               s_data,
    // result channel
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output hpec_out_t                   m_data,
    // configuration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_PIXELS - 1);

    hpec_cfg_t cfg;

    // Control state
    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  msg_reg, msg_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic                m_valid_reg, m_valid_next;

    // Payload holding registers
    logic [1:0]          kind_reg, kind_next;
    logic [9:0]          x_reg, x_next;
    logic [9:0]          y_reg, y_next;
    logic [THR_W-1:0]    thr_reg;
    hpec_out_t           pend_reg, pend_next;
    hpec_out_t           m_data_reg, m_data_next;

    // Locate results, valid in ST_READ
    logic [ADDR_W-1:0]   loc_index;
    logic                loc_in_sensor;

    // Pixel store port signals
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    hpec_entry_t         ram_wdata;
    logic                ram_re;
    hpec_entry_t         ram_rdata;

    logic [PROD_W-1:0]   thr_prod;
    logic [COUNT_W-1:0]  stamp_now;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Stamp for the current message; wraps with the message counter
    assign stamp_now = msg_reg + COUNT_W'(1);

    // Threshold: floor(fraction * messages / 65536), registered before compare
    assign thr_prod = PROD_W'(cfg.threshold_fraction) * PROD_W'(msg_reg);

    hpec_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hpec_locate #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_locate (
        .aclk      (aclk),
        .pixel_x   (x_reg),
        .pixel_y   (y_reg),
        .cfg       (cfg),
        .index     (loc_index),
        .in_sensor (loc_in_sensor)
    );

    // Count and stamp share one entry so a single read serves both
    hpec_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (loc_index),
        .rdata (ram_rdata)
    );

    // Next state and outputs. Only one request is in flight, so the write
    // back in ST_MODIFY always lands before the next read of the store:
    // no forwarding path is needed.
    always_comb begin
        state_next    = state_reg;
        msg_next      = msg_reg;
        clr_addr_next = clr_addr_reg;
        kind_next     = kind_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        pend_next     = pend_reg;
        m_data_next   = m_data_reg;
        // drop the result once taken
        m_valid_next  = m_valid_reg && !m_ready;
        s_ready       = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = loc_index;
        ram_wdata     = '0;
        ram_re        = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                // sweep the store to zero count, zero stamp
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end

            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next = s_data.kind;
                    x_next    = s_data.pixel_x;
                    y_next    = s_data.pixel_y;
                    case (s_data.kind)
                        KIND_EVENT, KIND_QUERY: begin
                            state_next = ST_CALC;
                        end
                        KIND_EOM: begin
                            // advance the message counter, no store access
                            msg_next = msg_reg + COUNT_W'(1);
                        end
                        default: ;
                    endcase
                end
            end

            ST_CALC: begin
                // locate unit and threshold product register this cycle
                state_next = ST_READ;
            end

            ST_READ: begin
                if (loc_in_sensor) begin
                    ram_re     = 1'b1;
                    state_next = ST_MODIFY;
                end else if (kind_reg == KIND_QUERY) begin
                    pend_next.fire_count = '0;
                    pend_next.is_bad     = 1'b0;
                    pend_next.status     = STATUS_OUTSIDE;
                    state_next           = ST_RESP;
                end else begin
                    // event outside the sensor: drop
                    state_next = ST_IDLE;
                end
            end

            ST_MODIFY: begin
                if (kind_reg == KIND_EVENT) begin
                    // count at most once per message
                    if (ram_rdata.stamp != stamp_now) begin
                        ram_we          = 1'b1;
                        ram_wdata.stamp = stamp_now;
                        ram_wdata.count = (ram_rdata.count == COUNT_MAX)
                                        ? ram_rdata.count
                                        : ram_rdata.count + COUNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end else begin
                    pend_next.fire_count = ram_rdata.count;
                    pend_next.is_bad     = ({1'b0, ram_rdata.count} >= thr_reg);
                    pend_next.status     = STATUS_OK;
                    state_next           = ST_RESP;
                end
            end

            ST_RESP: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            msg_reg      <= '0;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            msg_reg      <= msg_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
        thr_reg    <= thr_prod[PROD_W-1:16];
    end

`ifndef NO_ASSERTIONS
    // No request is taken while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("request accepted during clearing pass");

    // An end-of-message request advances the message counter by one
    a_eom_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.kind == KIND_EOM))
        |=> (msg_reg == $past(msg_reg) + COUNT_W'(1)))
        else $error("message counter did not advance on end of message");

    // The store is written only by the clearing pass or an event write back
    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ((state_reg == ST_CLEAR)
                 || ((state_reg == ST_MODIFY) && (kind_reg == KIND_EVENT))))
        else $error("unexpected pixel store write");

    // An event write back never lowers a pixel count
    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && (state_reg == ST_MODIFY))
        |-> (ram_wdata.count >= ram_rdata.count))
        else $error("pixel count decreased");

    // A query result is loaded only from the response state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && m_valid_next) |-> (state_reg == ST_RESP))
        else $error("result raised outside response state");
`endif

endmodule

`default_nettype wire
